// ===== hw/rtl/rcm_pkg.sv =====
// ----------------------------------------------------------------------------
// rcm_pkg
// Shared constants and types for the rod cutting revenue block.
// ----------------------------------------------------------------------------
package rcm_pkg;

  localparam int MAX_LEN    = 64;
  localparam int PRICE_BITS = 16;

  localparam int PRICE_IN_W = 16;
  localparam int OUT_LEN_W  = 7;
  localparam int OUT_REV_W  = 22;

  localparam int PRICE_AW = $clog2(MAX_LEN);
  localparam int REV_AW   = $clog2(MAX_LEN + 1);
  localparam int LEN_W    = $clog2(MAX_LEN + 2);
  localparam int REV_W    = PRICE_BITS + $clog2(MAX_LEN) + 1;

  localparam logic [OUT_REV_W-1:0] OUT_REV_MAX = {OUT_REV_W{1'b1}};

  typedef struct packed {
    logic [PRICE_IN_W-1:0] price;
    logic                  is_last;
  } rcm_in_t;

  typedef struct packed {
    logic [OUT_LEN_W-1:0] piece_length;
    logic [OUT_REV_W-1:0] best_revenue;
    logic [OUT_LEN_W-1:0] first_cut;
    logic                 last_result;
    logic                 overflow;
  } rcm_out_t;

  typedef struct packed {
    logic             start;
    logic             vld;
    logic             zero;
    logic [LEN_W-1:0] cut;
  } rcm_step_t;

endpackage

// ===== hw/rtl/rcm_ram.sv =====
// ----------------------------------------------------------------------------
// rcm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rcm_best.sv =====
// ----------------------------------------------------------------------------
// rcm_best
// Add-compare unit: folds price + revenue candidates into a running maximum.
// ----------------------------------------------------------------------------
module rcm_best (
  input  logic                           clk,
  input  rcm_pkg::rcm_step_t             step,
  input  logic [rcm_pkg::PRICE_BITS-1:0] pdata,
  input  logic [rcm_pkg::REV_W-1:0]      rdata,
  output logic [rcm_pkg::REV_W-1:0]      best,
  output logic [rcm_pkg::LEN_W-1:0]      cut
);
  import rcm_pkg::*;

  logic             have;
  logic [REV_W-1:0] cand;

  // entry zero of the revenue table is zero by definition
  assign cand = REV_W'(pdata) + (step.zero ? '0 : rdata);

  always_ff @(posedge clk) begin
    if (step.start) begin
      have <= 1'b0;
    end else if (step.vld && (!have || best < cand)) begin
      have <= 1'b1;
      best <= cand;
      cut  <= step.cut;
    end
  end

endmodule

// ===== hw/rtl/rod_cutting_max_revenue.sv =====
// ----------------------------------------------------------------------------
// rod_cutting_max_revenue
// Bottom-up rod cutting: stores each price while the rod has room and
// computes the best revenue and first cut for the current length.
// A request for length j reads the price and revenue memories one entry per
// cycle, folds the candidates into a running maximum, writes the best
// revenue back and registers it on the output before taking a new price.
// A price arriving with the rod full is dropped and flagged as overflow.
// Reset clears the length count and control; the memories are not cleared.
// ----------------------------------------------------------------------------
module rod_cutting_max_revenue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rcm_pkg::rcm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rcm_pkg::rcm_out_t out_data
);
  import rcm_pkg::*;

  typedef enum logic [1:0] {IDLE, RUN, FINISH} state_t;

  state_t           state;
  logic [LEN_W-1:0] count;
  logic [LEN_W-1:0] j;
  logic [LEN_W-1:0] iss_i;
  logic [LEN_W-1:0] held_cut;
  logic [REV_W-1:0] held_rev;
  logic             last_flag;
  logic             ovf_flag;
  rcm_step_t        step;

  logic                  in_acc;
  logic                  room;
  logic                  issuing;
  logic                  run_done;
  logic [LEN_W-1:0]      rev_idx;
  logic [PRICE_BITS-1:0] pdata;
  logic [REV_W-1:0]      rdata;
  logic [REV_W-1:0]      best;
  logic [LEN_W-1:0]      cut;

  assign in_ready = (state == IDLE);
  assign in_acc   = in_valid && in_ready;
  assign room     = count < LEN_W'(MAX_LEN);
  assign issuing  = (state == RUN) && (iss_i <= j);
  assign run_done = (state == RUN) && (iss_i > j) && !step.vld;
  assign rev_idx  = j - iss_i;

  rcm_ram #(.WIDTH(PRICE_BITS), .DEPTH(MAX_LEN)) u_price_ram (
    .clk   (clk),
    .we    (in_acc && room),
    .waddr (count[PRICE_AW-1:0]),
    .wdata (in_data.price[PRICE_BITS-1:0]),
    .raddr (PRICE_AW'(iss_i - LEN_W'(1))),
    .rdata (pdata)
  );

  rcm_ram #(.WIDTH(REV_W), .DEPTH(MAX_LEN + 1)) u_rev_ram (
    .clk   (clk),
    .we    (run_done),
    .waddr (j[REV_AW-1:0]),
    .wdata (best),
    .raddr (rev_idx[REV_AW-1:0]),
    .rdata (rdata)
  );

  rcm_best u_best (
    .clk   (clk),
    .step  (step),
    .pdata (pdata),
    .rdata (rdata),
    .best  (best),
    .cut   (cut)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      count     <= '0;
      held_cut  <= '0;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      step.start <= 1'b0;
      step.vld   <= issuing;
      step.zero  <= (rev_idx == '0);
      step.cut   <= iss_i;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (in_acc) begin
            last_flag <= in_data.is_last;
            if (room) begin
              ovf_flag   <= 1'b0;
              j          <= count + LEN_W'(1);
              iss_i      <= LEN_W'(1);
              step.start <= 1'b1;
              state      <= RUN;
            end else begin
              ovf_flag <= 1'b1;
              j        <= LEN_W'(MAX_LEN);
              state    <= FINISH;
            end
          end
        end
        RUN: begin
          if (issuing) begin
            iss_i <= iss_i + LEN_W'(1);
          end
          if (run_done) begin
            held_rev <= best;
            held_cut <= cut;
            state    <= FINISH;
          end
        end
        FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid             <= 1'b1;
            out_data.piece_length <= OUT_LEN_W'(j);
            out_data.best_revenue <= (held_rev > REV_W'(OUT_REV_MAX)) ?
                                     OUT_REV_MAX : OUT_REV_W'(held_rev);
            out_data.first_cut    <= OUT_LEN_W'(held_cut);
            out_data.last_result  <= last_flag;
            out_data.overflow     <= ovf_flag;
            count                 <= last_flag ? '0 : j;
            state                 <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
